FILE: hw/rtl/csvg_pkg.sv
// Shared types, constants and rounding helper for the circle segment vertex generator.
package csvg_pkg;

  typedef enum logic [3:0] {
    REG_CENTER_X      = 4'd0,
    REG_CENTER_Y      = 4'd1,
    REG_CENTER_Z      = 4'd2,
    REG_CIRCLE_RADIUS = 4'd3,
    REG_NORMAL_X      = 4'd4,
    REG_NORMAL_Y      = 4'd5,
    REG_NORMAL_Z      = 4'd6,
    REG_SEGMENT_COUNT = 4'd7
  } cfg_reg_t;

  localparam logic [13:0] MIN_COUNT   = 14'd3;
  localparam logic [13:0] MAX_COUNT   = 14'd10000;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
  localparam logic [31:0] CORDIC_X0   = 32'd652032874;

  // phase divider: 15 index bits plus 32 fraction bits, a few steps per stage
  localparam int DIV_BITS      = 47;
  localparam int DIV_PER_STAGE = 4;
  localparam int DIV_STAGES    = (DIV_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  localparam logic [31:0] ATAN_Q30 [30] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
  };

  // right shift, rounding half away from zero
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int s);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

FILE: hw/rtl/csvg_basis.sv
// In-plane basis unit: normalizes the plane normal and builds b1, b2 step by step in a state machine.
module csvg_basis #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [15:0]              normal_x,
  input  logic signed [15:0]              normal_y,
  input  logic signed [15:0]              normal_z,
  output logic                            busy,
  output logic signed [FRACTION_BITS+1:0] b1 [3],
  output logic signed [FRACTION_BITS+1:0] b2 [3]
);

  localparam int BW = FRACTION_BITS + 2;
  localparam int RS = 30 - FRACTION_BITS;

  typedef enum logic [2:0] {
    B_IDLE, B_SETUP, B_SQRT, B_DLOAD, B_DIV, B_CROSS, B_ROUND
  } state_t;

  state_t             state;
  logic [5:0]         cnt;
  logic [2:0]         sel;
  logic [31:0]        l2;
  logic [63:0]        sq_v, sq_r, sq_bit;
  logic [31:0]        sl, ln;
  logic [32:0]        dv_rem;
  logic [62:0]        dv_num, dv_q;
  logic [31:0]        dv_den;
  logic               dv_neg;
  logic signed [31:0] u [3];
  logic signed [31:0] b1q [3];
  logic signed [33:0] b2q [3];

  // combinational helpers
  logic [31:0]        s2_c, l2_c;
  logic [63:0]        sq_sum, sq_r_next;
  logic               sq_ge;
  logic [33:0]        dv_rr;
  logic               dv_ge;
  logic [32:0]        dv_rem_next;
  logic [62:0]        dv_q_next;
  logic signed [31:0] dv_res;
  logic [30:0]        dv_clamp;
  logic signed [15:0] ld_comp;
  logic [15:0]        ld_mag;
  logic               ld_neg;
  logic [31:0]        ld_den;
  logic signed [63:0] xa, xb, xd;

  assign busy = (state != B_IDLE);

  always_comb begin
    s2_c = 32'($signed(normal_y) * $signed(normal_y)) + 32'($signed(normal_z) * $signed(normal_z));
    l2_c = s2_c + 32'($signed(normal_x) * $signed(normal_x));

    sq_sum    = sq_r + sq_bit;
    sq_ge     = (sq_v >= sq_sum);
    sq_r_next = sq_ge ? ((sq_r >> 1) + sq_bit) : (sq_r >> 1);

    dv_rr       = {dv_rem, dv_num[62]};
    dv_ge       = (dv_rr >= {2'b00, dv_den});
    dv_rem_next = dv_ge ? 33'(dv_rr - {2'b00, dv_den}) : dv_rr[32:0];
    dv_q_next   = {dv_q[61:0], dv_ge};
    dv_clamp    = (dv_q_next > 63'(csvg_pkg::Q30_ONE)) ? csvg_pkg::Q30_ONE : dv_q_next[30:0];
    dv_res      = dv_neg ? -$signed({1'b0, dv_clamp}) : $signed({1'b0, dv_clamp});

    // numerator and denominator of the ratio selected by sel
    unique case (sel)
      3'd0:    begin ld_comp = normal_x; ld_den = ln; ld_neg = normal_x[15]; end
      3'd1:    begin ld_comp = normal_y; ld_den = ln; ld_neg = normal_y[15]; end
      3'd2:    begin ld_comp = normal_z; ld_den = ln; ld_neg = normal_z[15]; end
      3'd3:    begin ld_comp = normal_z; ld_den = sl; ld_neg = normal_z[15]; end
      3'd4:    begin ld_comp = normal_y; ld_den = sl; ld_neg = !normal_y[15] && normal_y != 16'sd0; end
      default: begin ld_comp = 16'sd0;   ld_den = sl; ld_neg = 1'b0; end
    endcase
    ld_mag = ld_comp[15] ? 16'(-ld_comp) : 16'(ld_comp);

    // cross product b2 = b1 x u, one component per cycle
    unique case (cnt[1:0])
      2'd0:    begin xa = b1q[1] * u[2]; xb = b1q[2] * u[1]; end
      2'd1:    begin xa = b1q[2] * u[0]; xb = 64'sd0; end
      2'd2:    begin xa = 64'sd0;        xb = b1q[1] * u[0]; end
      default: begin xa = 64'sd0;        xb = 64'sd0; end
    endcase
    xd = xa - xb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_SETUP;
      cnt   <= '0;
      sel   <= '0;
    end else if (start) begin
      state <= B_SETUP;
    end else begin
      unique case (state)
        B_IDLE: begin
        end
        B_SETUP: begin
          cnt <= '0;
          sel <= '0;
          if (normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0) begin
            for (int a = 0; a < 3; a++) begin
              b1q[a] <= '0;
              b2q[a] <= '0;
            end
            state <= B_ROUND;
          end else if (normal_y == 16'sd0 && normal_z == 16'sd0) begin
            b1q[0] <= '0;
            b1q[1] <= -$signed({1'b0, csvg_pkg::Q30_ONE});
            b1q[2] <= '0;
            b2q[0] <= '0;
            b2q[1] <= '0;
            b2q[2] <= normal_x[15] ? 34'($signed({1'b0, csvg_pkg::Q30_ONE}))
                                   : -34'($signed({1'b0, csvg_pkg::Q30_ONE}));
            state <= B_ROUND;
          end else begin
            l2     <= l2_c;
            sq_v   <= {s2_c, 32'd0};
            sq_r   <= '0;
            sq_bit <= 64'd1 << 62;
            b1q[0] <= '0;
            state  <= B_SQRT;
          end
        end
        B_SQRT: begin
          if (cnt == 6'd31) begin
            cnt <= '0;
            if (sel == 3'd0) begin
              sl     <= sq_r_next[31:0];
              sq_v   <= {l2, 32'd0};
              sq_r   <= '0;
              sq_bit <= 64'd1 << 62;
              sel    <= 3'd1;
            end else begin
              ln    <= sq_r_next[31:0];
              sel   <= '0;
              state <= B_DLOAD;
            end
          end else begin
            if (sq_ge) sq_v <= sq_v - sq_sum;
            sq_r   <= sq_r_next;
            sq_bit <= sq_bit >> 2;
            cnt    <= cnt + 6'd1;
          end
        end
        B_DLOAD: begin
          dv_num <= 63'({ld_mag, 46'd0}) + 63'(ld_den >> 1);
          dv_den <= ld_den;
          dv_neg <= ld_neg;
          dv_rem <= '0;
          dv_q   <= '0;
          cnt    <= '0;
          state  <= B_DIV;
        end
        B_DIV: begin
          dv_rem <= dv_rem_next;
          dv_q   <= dv_q_next;
          dv_num <= dv_num << 1;
          if (cnt == 6'd62) begin
            unique case (sel)
              3'd0:    u[0]   <= dv_res;
              3'd1:    u[1]   <= dv_res;
              3'd2:    u[2]   <= dv_res;
              3'd3:    b1q[1] <= dv_res;
              default: b1q[2] <= dv_res;
            endcase
            cnt <= '0;
            if (sel == 3'd4) begin
              state <= B_CROSS;
            end else begin
              sel   <= sel + 3'd1;
              state <= B_DLOAD;
            end
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        B_CROSS: begin
          b2q[cnt[1:0]] <= 34'(csvg_pkg::rshr(xd, 30));
          cnt <= cnt + 6'd1;
          if (cnt == 6'd2) state <= B_ROUND;
        end
        B_ROUND: begin
          for (int a = 0; a < 3; a++) begin
            b1[a] <= BW'(csvg_pkg::rshr(64'(b1q[a]), RS));
            b2[a] <= BW'(csvg_pkg::rshr(64'(b2q[a]), RS));
          end
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/circle_segment_vertex_generator.sv
// Throughput: one request per cycle while seg_stall is low; every stage is registered and advances together.
// A normal write (and reset) starts the basis unit, which runs its square roots and ratio
// divisions; requests and config writes are stalled until it finishes.
// Reset (rst, synchronous) loads the default circle and empties the pipeline and output.
module circle_segment_vertex_generator #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // segment request channel
  input  logic               seg_valid,
  output logic               seg_stall,
  input  logic [13:0]        segment_index,
  // vertex result channel
  output logic               vtx_valid,
  input  logic               vtx_stall,
  output logic signed [31:0] start_x,
  output logic signed [31:0] start_y,
  output logic signed [31:0] start_z,
  output logic signed [31:0] end_x,
  output logic signed [31:0] end_y,
  output logic signed [31:0] end_z,
  output logic               index_valid,
  output logic               saturated,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int DS  = csvg_pkg::DIV_STAGES;
  localparam int XW  = 34;                  // CORDIC x/y, Q2.30 plus gain headroom
  localparam int ZW  = 33;                  // CORDIC angle residue
  localparam int CW  = FRACTION_BITS + 2;   // cos/sin in Q.F
  localparam int BW  = FRACTION_BITS + 2;   // basis in Q.F
  localparam int PW  = CW + BW;
  localparam int WW  = FRACTION_BITS + 4;   // unit-circle point in Q.F
  localparam int RW  = 32 + WW;
  localparam int RS  = 30 - FRACTION_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] ctr [3];
  logic [30:0]        circle_radius;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic [13:0]        segment_count;
  logic               cfg_write;
  logic               basis_start;
  logic               basis_busy;
  logic [13:0]        count_raw;
  logic signed [BW-1:0] b1 [3];
  logic signed [BW-1:0] b2 [3];

  assign cfg_ready   = !basis_busy;
  assign cfg_write   = cfg_valid && cfg_ready;
  assign count_raw   = cfg_data[13:0];
  // any normal write invalidates the basis
  assign basis_start = cfg_write && (cfg_index == csvg_pkg::REG_NORMAL_X ||
                                     cfg_index == csvg_pkg::REG_NORMAL_Y ||
                                     cfg_index == csvg_pkg::REG_NORMAL_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr[0]        <= '0;
      ctr[1]        <= '0;
      ctr[2]        <= '0;
      circle_radius <= 31'd65536;
      normal_x      <= '0;
      normal_y      <= '0;
      normal_z      <= 16'sd16384;
      segment_count <= csvg_pkg::MIN_COUNT;
    end else if (cfg_write) begin
      case (cfg_index)
        csvg_pkg::REG_CENTER_X:      ctr[0]        <= cfg_data;
        csvg_pkg::REG_CENTER_Y:      ctr[1]        <= cfg_data;
        csvg_pkg::REG_CENTER_Z:      ctr[2]        <= cfg_data;
        csvg_pkg::REG_CIRCLE_RADIUS: circle_radius <= cfg_data[30:0];
        csvg_pkg::REG_NORMAL_X:      normal_x      <= cfg_data[15:0];
        csvg_pkg::REG_NORMAL_Y:      normal_y      <= cfg_data[15:0];
        csvg_pkg::REG_NORMAL_Z:      normal_z      <= cfg_data[15:0];
        csvg_pkg::REG_SEGMENT_COUNT: begin
          // writes are clamped to the supported side count range
          if (count_raw < csvg_pkg::MIN_COUNT)      segment_count <= csvg_pkg::MIN_COUNT;
          else if (count_raw > csvg_pkg::MAX_COUNT) segment_count <= csvg_pkg::MAX_COUNT;
          else                                      segment_count <= count_raw;
        end
        default: begin
        end
      endcase
    end
  end

  csvg_basis #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_basis (
    .clk      (clk),
    .rst      (rst),
    .start    (basis_start),
    .normal_x (normal_x),
    .normal_y (normal_y),
    .normal_z (normal_z),
    .busy     (basis_busy),
    .b1       (b1),
    .b2       (b2)
  );

  // ---------------------------------------------------------------------------
  // Pipeline control. All stages share one enable; the output register plus a
  // one-entry skid buffer decouple the pipeline from a stalled consumer, so the
  // pipe keeps flowing while one result waits.
  // ---------------------------------------------------------------------------
  logic en;
  logic skid_valid;
  logic seg_accept;

  assign en         = !skid_valid;
  assign seg_stall  = skid_valid || basis_busy || cfg_valid;
  assign seg_accept = seg_valid && !seg_stall;

  // ---------------------------------------------------------------------------
  // Phase divider: phase = round(k * 2^32 / n) mod 2^32 by restoring division.
  // Lane 0 is the start vertex (k = i), lane 1 the end vertex (k = i + 1).
  // Only the low 32 quotient bits are kept; the remainder stays below n.
  // ---------------------------------------------------------------------------
  logic [13:0] dr [DS+1][2];
  logic [46:0] dd [DS+1][2];
  logic [31:0] dq [DS+1][2];
  logic        dvld [DS+1];
  logic        dok  [DS+1];
  logic [13:0] dr_next [DS][2];
  logic [46:0] dd_next [DS][2];
  logic [31:0] dq_next [DS][2];

  always_comb begin : div_steps
    logic [13:0] r;
    logic [46:0] d;
    logic [31:0] q;
    logic [14:0] rr;
    for (int s = 0; s < DS; s++) begin
      for (int e = 0; e < 2; e++) begin
        r = dr[s][e];
        d = dd[s][e];
        q = dq[s][e];
        for (int j = 0; j < csvg_pkg::DIV_PER_STAGE; j++) begin
          if (s * csvg_pkg::DIV_PER_STAGE + j < csvg_pkg::DIV_BITS) begin
            rr = {r, d[46]};
            if (rr >= {1'b0, segment_count}) begin
              r = 14'(rr - {1'b0, segment_count});
              q = {q[30:0], 1'b1};
            end else begin
              r = rr[13:0];
              q = {q[30:0], 1'b0};
            end
            d = d << 1;
          end
        end
        dr_next[s][e] = r;
        dd_next[s][e] = d;
        dq_next[s][e] = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DS; s++) dvld[s] <= 1'b0;
    end else if (en) begin
      dvld[0] <= seg_accept;
      for (int s = 0; s < DS; s++) dvld[s+1] <= dvld[s];
    end
    if (en) begin
      // entry: dividend = k * 2^32 + floor(n / 2)
      dok[0] <= (segment_index < segment_count);
      dd[0][0] <= {1'b0, segment_index, 32'(segment_count >> 1)};
      dd[0][1] <= {15'({1'b0, segment_index} + 15'd1), 32'(segment_count >> 1)};
      for (int e = 0; e < 2; e++) begin
        dr[0][e] <= '0;
        dq[0][e] <= '0;
      end
      for (int s = 0; s < DS; s++) begin
        dok[s+1] <= dok[s];
        for (int e = 0; e < 2; e++) begin
          dr[s+1][e] <= dr_next[s][e];
          dd[s+1][e] <= dd_next[s][e];
          dq[s+1][e] <= dq_next[s][e];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Quadrant split and turns-to-radians scaling of the in-quadrant phase
  // ---------------------------------------------------------------------------
  logic [60:0] mp [2];
  logic [1:0]  mq [2];
  logic        mv, mok;

  always_ff @(posedge clk) begin
    if (rst)     mv <= 1'b0;
    else if (en) mv <= dvld[DS];
    if (en) begin
      mok <= dok[DS];
      for (int e = 0; e < 2; e++) begin
        mp[e] <= 61'(dq[DS][e][29:0]) * 61'(csvg_pkg::PI_HALF_Q30);
        mq[e] <= dq[DS][e][31:30];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC rotation, one micro-rotation per stage, both lanes side by side
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0] cx [CORDIC_STAGES+1][2];
  logic signed [XW-1:0] cy [CORDIC_STAGES+1][2];
  logic signed [ZW-1:0] cz [CORDIC_STAGES+1][2];
  logic [1:0]           cq [CORDIC_STAGES+1][2];
  logic                 cv  [CORDIC_STAGES+1];
  logic                 cok [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= CORDIC_STAGES; i++) cv[i] <= 1'b0;
    end else if (en) begin
      cv[0] <= mv;
      for (int i = 0; i < CORDIC_STAGES; i++) cv[i+1] <= cv[i];
    end
    if (en) begin
      cok[0] <= mok;
      for (int e = 0; e < 2; e++) begin
        cx[0][e] <= XW'(csvg_pkg::CORDIC_X0);
        cy[0][e] <= '0;
        cz[0][e] <= ZW'((mp[e] + (61'd1 << 29)) >> 30);
        cq[0][e] <= mq[e];
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        cok[i+1] <= cok[i];
        for (int e = 0; e < 2; e++) begin
          cq[i+1][e] <= cq[i][e];
          if (!cz[i][e][ZW-1]) begin
            cx[i+1][e] <= cx[i][e] - (cy[i][e] >>> i);
            cy[i+1][e] <= cy[i][e] + (cx[i][e] >>> i);
            cz[i+1][e] <= cz[i][e] - ZW'(csvg_pkg::ATAN_Q30[i]);
          end else begin
            cx[i+1][e] <= cx[i][e] + (cy[i][e] >>> i);
            cy[i+1][e] <= cy[i][e] - (cx[i][e] >>> i);
            cz[i+1][e] <= cz[i][e] + ZW'(csvg_pkg::ATAN_Q30[i]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Quadrant fold-back and rounding of cos/sin to Q.F
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0] c_raw [2];
  logic signed [XW-1:0] s_raw [2];
  logic signed [CW-1:0] cc [2];
  logic signed [CW-1:0] ss [2];
  logic                 tv, tok;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      unique case (cq[CORDIC_STAGES][e])
        2'd0: begin c_raw[e] =  cx[CORDIC_STAGES][e]; s_raw[e] =  cy[CORDIC_STAGES][e]; end
        2'd1: begin c_raw[e] = -cy[CORDIC_STAGES][e]; s_raw[e] =  cx[CORDIC_STAGES][e]; end
        2'd2: begin c_raw[e] = -cx[CORDIC_STAGES][e]; s_raw[e] = -cy[CORDIC_STAGES][e]; end
        2'd3: begin c_raw[e] =  cy[CORDIC_STAGES][e]; s_raw[e] = -cx[CORDIC_STAGES][e]; end
        default: begin c_raw[e] = '0; s_raw[e] = '0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst)     tv <= 1'b0;
    else if (en) tv <= cv[CORDIC_STAGES];
    if (en) begin
      tok <= cok[CORDIC_STAGES];
      for (int e = 0; e < 2; e++) begin
        cc[e] <= CW'(csvg_pkg::rshr(64'(c_raw[e]), RS));
        ss[e] <= CW'(csvg_pkg::rshr(64'(s_raw[e]), RS));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Point on the unit circle in the plane: w = cos*b1 + sin*b2
  // (a zero normal leaves b1 = b2 = 0, so the offset collapses to zero)
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] pa [2][3];
  logic signed [PW-1:0] pb [2][3];
  logic                 pv, pok;
  logic signed [WW-1:0] w [2][3];
  logic                 wv, wok;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
      wv <= 1'b0;
    end else if (en) begin
      pv <= tv;
      wv <= pv;
    end
    if (en) begin
      pok <= tok;
      wok <= pok;
      for (int e = 0; e < 2; e++) begin
        for (int a = 0; a < 3; a++) begin
          pa[e][a] <= cc[e] * b1[a];
          pb[e][a] <= ss[e] * b2[a];
          w[e][a]  <= WW'(csvg_pkg::rshr(64'(pa[e][a]) + 64'(pb[e][a]), FRACTION_BITS));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scale by radius, add centre, saturate to 32 bits
  // ---------------------------------------------------------------------------
  logic signed [RW-1:0] rp [2][3];
  logic                 rv, rok;
  logic signed [63:0]   fsum [2][3];
  logic signed [31:0]   fval [2][3];
  logic                 fclip;

  always_comb begin
    fclip = 1'b0;
    for (int e = 0; e < 2; e++) begin
      for (int a = 0; a < 3; a++) begin
        fsum[e][a] = 64'(ctr[a]) + csvg_pkg::rshr(64'(rp[e][a]), FRACTION_BITS);
        if (fsum[e][a] > 64'sh7FFF_FFFF) begin
          fval[e][a] = 32'sh7FFF_FFFF;
          fclip      = 1'b1;
        end else if (fsum[e][a] < -64'sh8000_0000) begin
          fval[e][a] = 32'sh8000_0000;
          fclip      = 1'b1;
        end else begin
          fval[e][a] = fsum[e][a][31:0];
        end
      end
    end
  end

  logic               fv, fok, fsat;
  logic signed [31:0] fx [2][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
      fv <= 1'b0;
    end else if (en) begin
      rv <= wv;
      fv <= rv;
    end
    if (en) begin
      rok  <= wok;
      fok  <= rok;
      fsat <= fclip;
      for (int e = 0; e < 2; e++) begin
        for (int a = 0; a < 3; a++) begin
          rp[e][a] <= $signed({1'b0, circle_radius}) * w[e][a];
          fx[e][a] <= fval[e][a];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid buffer
  // ---------------------------------------------------------------------------
  logic signed [31:0] ox [2][3];
  logic               ook, osat;
  logic signed [31:0] kx [2][3];
  logic               kok, ksat;
  logic               take;

  assign take = vtx_valid && !vtx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // pipeline frozen; drain the parked result first
      if (take) begin
        ox         <= kx;
        ook        <= kok;
        osat       <= ksat;
        skid_valid <= 1'b0;
      end
    end else if (fv) begin
      if (!vtx_valid || take) begin
        ox        <= fx;
        ook       <= fok;
        osat      <= fsat;
        vtx_valid <= 1'b1;
      end else begin
        kx         <= fx;
        kok        <= fok;
        ksat       <= fsat;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      vtx_valid <= 1'b0;
    end
  end

  assign start_x     = ox[0][0];
  assign start_y     = ox[0][1];
  assign start_z     = ox[0][2];
  assign end_x       = ox[1][0];
  assign end_y       = ox[1][1];
  assign end_z       = ox[1][2];
  assign index_valid = ook;
  assign saturated   = osat;

endmodule

FILE: hw/rtl/csvg_checker.sv
// Port-level checker for the circle segment vertex generator, bound to the top level.
module csvg_checker (
  input logic               clk,
  input logic               rst,
  input logic               seg_valid,
  input logic               seg_stall,
  input logic               vtx_valid,
  input logic               vtx_stall,
  input logic signed [31:0] start_x,
  input logic signed [31:0] start_y,
  input logic signed [31:0] start_z,
  input logic signed [31:0] end_x,
  input logic signed [31:0] end_y,
  input logic signed [31:0] end_z,
  input logic               index_valid,
  input logic               saturated,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [3:0]         cfg_index
);

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !vtx_valid)
    else $error("result valid right after reset");

  // a stalled result holds its valid, start_x, end_z, saturated and index_valid
  a_hold: assert property (@(posedge clk) disable iff (rst)
    vtx_valid && vtx_stall |=> vtx_valid && $stable(start_x) && $stable(end_z) &&
                               $stable(saturated) && $stable(index_valid))
    else $error("stalled result changed");

  // a clamp flag must show on some coordinate at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    vtx_valid && saturated |->
      start_x == 32'sh7FFF_FFFF || start_x == 32'sh8000_0000 ||
      start_y == 32'sh7FFF_FFFF || start_y == 32'sh8000_0000 ||
      start_z == 32'sh7FFF_FFFF || start_z == 32'sh8000_0000 ||
      end_x   == 32'sh7FFF_FFFF || end_x   == 32'sh8000_0000 ||
      end_y   == 32'sh7FFF_FFFF || end_y   == 32'sh8000_0000 ||
      end_z   == 32'sh7FFF_FFFF || end_z   == 32'sh8000_0000)
    else $error("saturated without a clamped coordinate");

  // no request is taken in the cycle of a config write
  a_cfg_excl: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> !(seg_valid && !seg_stall))
    else $error("request accepted during config write");

  // a normal write starts the basis recompute, which blocks requests and config
  a_basis_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready &&
    (cfg_index == 4'(csvg_pkg::REG_NORMAL_X) || cfg_index == 4'(csvg_pkg::REG_NORMAL_Y) ||
     cfg_index == 4'(csvg_pkg::REG_NORMAL_Z))
    |=> !cfg_ready && seg_stall)
    else $error("basis recompute not blocking after normal write");

endmodule

bind circle_segment_vertex_generator csvg_checker u_csvg_checker (.*);

FILE: bench/circle_segment_vertex_generator_tb.sv
// Self-checking bench for the circle segment vertex generator, with a built-in vertex predictor.
module circle_segment_vertex_generator_tb;

  // Indexes past the last register; the block must ignore writes to them.
  localparam logic [3:0] REG_UNUSED_BASE = 4'd8;
  localparam int STAGES       = 16;
  localparam int FRAC         = 16;
  localparam int STALL_LIMIT  = 20000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES  = 1500;   // long output hold-off for the pressure test
  localparam int DRAIN_CYCLES = 60;     // extra wait after the last expected result arrives

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic               idx_ok;
    logic               sat;
  } vertex_pair_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               seg_valid = 1'b0;
  logic               seg_stall;
  logic [13:0]        segment_index = '0;
  logic               vtx_valid;
  logic               vtx_stall = 1'b0;
  logic signed [31:0] start_x, start_y, start_z, end_x, end_y, end_z;
  logic               index_valid, saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [3:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  circle_segment_vertex_generator #(
    .CORDIC_STAGES(STAGES),
    .FRACTION_BITS(FRAC)
  ) uut (
    .clk(clk), .rst(rst),
    .seg_valid(seg_valid), .seg_stall(seg_stall), .segment_index(segment_index),
    .vtx_valid(vtx_valid), .vtx_stall(vtx_stall),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .end_x(end_x), .end_y(end_y), .end_z(end_z),
    .index_valid(index_valid), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the circle registers, updated on every accepted write.
  logic signed [31:0] circ_cx, circ_cy, circ_cz;
  logic [30:0]        circ_radius;
  logic signed [15:0] circ_nx, circ_ny, circ_nz;
  logic [13:0]        circ_count;

  vertex_pair_t expected_vertices[$];
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int checked       = 0;
  int sent          = 0;
  int cfg_writes    = 0;
  int quiet_cycles  = 0;

  // ---------------------------------------------------------------------------
  // Fixed-point helpers
  // ---------------------------------------------------------------------------

  // Magnitude-based right shift, ties rounded away from zero.
  function automatic longint round_shift(longint v, int s);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q2.14 component over a Q2.30 length -> Q2.30, magnitude capped at one.
  function automatic longint unit_ratio(longint n, longint unsigned den);
    longint unsigned q, m;
    m = (n < 0) ? longint'(-n) : n;
    q = ((m << 46) + den / 2) / den;
    if (q > longint'(csvg_pkg::Q30_ONE)) q = longint'(csvg_pkg::Q30_ONE);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  // cos/sin of k/n turns through a quadrant fold and a CORDIC rotation.
  task automatic turn_cos_sin(input longint unsigned k, input longint unsigned n,
                              output longint c, output longint s);
    logic [31:0] phase;
    longint unsigned rem;
    longint x, y, z, t;
    phase = 32'(((k << 32) + n / 2) / n);
    rem = phase[29:0];
    z = longint'((rem * longint'(csvg_pkg::PI_HALF_Q30) + (64'd1 << 29)) >> 30);
    x = longint'(csvg_pkg::CORDIC_X0);
    y = 0;
    for (int i = 0; i < STAGES && i < 30; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t;
        z = z - longint'(csvg_pkg::ATAN_Q30[i]);
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t;
        z = z + longint'(csvg_pkg::ATAN_Q30[i]);
      end
    end
    case (phase[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = round_shift(c, 30 - FRAC);
    s = round_shift(s, 30 - FRAC);
  endtask

  task automatic predict_vertices(input logic [13:0] idx, output vertex_pair_t r);
    longint b1[3], b2[3], ctr[3], pt[6];
    longint nx, ny, nz, ux, uy, uz, c, s, w, off, v;
    longint unsigned s2, l2, sl, ln;
    bit degenerate, sat;
    nx = circ_nx; ny = circ_ny; nz = circ_nz;
    ctr[0] = circ_cx; ctr[1] = circ_cy; ctr[2] = circ_cz;
    b1 = '{0, 0, 0};
    b2 = '{0, 0, 0};
    degenerate = 0;
    sat = 0;
    if (nx == 0 && ny == 0 && nz == 0) begin
      degenerate = 1;
    end else if (ny == 0 && nz == 0) begin
      // normal along X: fixed basis, second vector flips with the sign of X
      b1[1] = -longint'(csvg_pkg::Q30_ONE);
      b2[2] = (nx > 0) ? -longint'(csvg_pkg::Q30_ONE) : longint'(csvg_pkg::Q30_ONE);
    end else begin
      s2 = ny * ny + nz * nz;
      l2 = s2 + nx * nx;
      sl = int_sqrt(s2 << 32);
      ln = int_sqrt(l2 << 32);
      ux = unit_ratio(nx, ln); uy = unit_ratio(ny, ln); uz = unit_ratio(nz, ln);
      b1[1] = unit_ratio(nz, sl);
      b1[2] = unit_ratio(-ny, sl);
      b2[0] = round_shift(b1[1] * uz - b1[2] * uy, 30);
      b2[1] = round_shift(b1[2] * ux, 30);
      b2[2] = round_shift(-b1[1] * ux, 30);
    end
    for (int a = 0; a < 3; a++) begin
      b1[a] = round_shift(b1[a], 30 - FRAC);
      b2[a] = round_shift(b2[a], 30 - FRAC);
    end
    for (int e = 0; e < 2; e++) begin
      turn_cos_sin(longint'(idx) + e, longint'(circ_count), c, s);
      for (int a = 0; a < 3; a++) begin
        off = 0;
        if (!degenerate) begin
          w = round_shift(c * b1[a] + s * b2[a], FRAC);
          off = round_shift(longint'(circ_radius) * w, FRAC);
        end
        v = ctr[a] + off;
        if (v > 64'sd2147483647) begin v = 64'sd2147483647; sat = 1; end
        if (v < -64'sd2147483648) begin v = -64'sd2147483648; sat = 1; end
        pt[e * 3 + a] = v;
      end
    end
    r.sx = pt[0][31:0]; r.sy = pt[1][31:0]; r.sz = pt[2][31:0];
    r.ex = pt[3][31:0]; r.ey = pt[4][31:0]; r.ez = pt[5][31:0];
    r.idx_ok = (idx < circ_count);
    r.sat = sat;
  endtask

  function automatic void shadow_write(logic [3:0] idx, logic [31:0] data);
    logic [13:0] n;
    case (idx)
      csvg_pkg::REG_CENTER_X:      circ_cx = data;
      csvg_pkg::REG_CENTER_Y:      circ_cy = data;
      csvg_pkg::REG_CENTER_Z:      circ_cz = data;
      csvg_pkg::REG_CIRCLE_RADIUS: circ_radius = data[30:0];
      csvg_pkg::REG_NORMAL_X:      circ_nx = data[15:0];
      csvg_pkg::REG_NORMAL_Y:      circ_ny = data[15:0];
      csvg_pkg::REG_NORMAL_Z:      circ_nz = data[15:0];
      csvg_pkg::REG_SEGMENT_COUNT: begin
        n = data[13:0];
        if (n < csvg_pkg::MIN_COUNT) n = csvg_pkg::MIN_COUNT;
        if (n > csvg_pkg::MAX_COUNT) n = csvg_pkg::MAX_COUNT;
        circ_count = n;
      end
      default: ;  // unused index, dropped
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Channel tasks
  // ---------------------------------------------------------------------------

  // Offer one request; returns in the step of the edge that accepted it, with
  // valid still high so a back-to-back request needs no extra assignment.
  task automatic send_segment(input logic [13:0] idx);
    vertex_pair_t exp_v;
    if ($urandom_range(99) < src_idle_pct) begin
      seg_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    seg_valid <= 1'b1;
    segment_index <= idx;
    predict_vertices(idx, exp_v);
    do @(posedge clk); while (seg_stall);
    expected_vertices = {expected_vertices, exp_v};
    sent++;
  endtask

  // Drop valid (same step as the last acceptance) and let the pipe empty.
  task automatic drain;
    seg_valid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One write; valid drops for a cycle before the next write can start.
  task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_write(idx, data);
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic load_circle(input logic [31:0] cx, cy, cz, input logic [30:0] rad,
                             input logic [15:0] nx, ny, nz, input logic [13:0] cnt);
    drain();
    write_reg(csvg_pkg::REG_CENTER_X, cx);
    write_reg(csvg_pkg::REG_CENTER_Y, cy);
    write_reg(csvg_pkg::REG_CENTER_Z, cz);
    write_reg(csvg_pkg::REG_CIRCLE_RADIUS, {1'b0, rad});
    write_reg(csvg_pkg::REG_NORMAL_X, {16'(0), nx});
    write_reg(csvg_pkg::REG_NORMAL_Y, {16'(0), ny});
    write_reg(csvg_pkg::REG_NORMAL_Z, {16'(0), nz});
    write_reg(csvg_pkg::REG_SEGMENT_COUNT, {18'(0), cnt});
  endtask

  task automatic load_random_circle;
    logic [31:0] c[3];
    logic [30:0] rad;
    logic [15:0] n[3];
    logic [13:0] cnt;
    for (int a = 0; a < 3; a++) begin
      c[a] = ($urandom_range(3) == 0) ? $urandom : 32'($signed(16'($urandom))) <<< 8;
      n[a] = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
    end
    rad = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(1 << 24));
    case ($urandom_range(5))
      0:       cnt = 14'($urandom);             // wide, clamps above the maximum
      1:       cnt = csvg_pkg::MAX_COUNT;
      default: cnt = 14'($urandom_range(3, 40));
    endcase
    load_circle(c[0], c[1], c[2], rad, n[0], n[1], n[2], cnt);
  endtask

  // Mostly real sides; the rest spans the whole index field.
  function automatic logic [13:0] pick_index;
    if ($urandom_range(9) < 7) return 14'($urandom_range(circ_count - 1));
    return 14'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset circle: unit radius about the origin in the XY plane, three sides.
  task automatic test_reset_circle;
    send_segment(14'd0);
    send_segment(14'd1);
    send_segment(14'd2);        // last side wraps to a full turn
    send_segment(14'd3);        // just past the count
    send_segment(14'h3FFF);     // top of the index field
  endtask

  task automatic test_basis_cases;
    // zero normal: both endpoints sit on the centre
    load_circle(32'h0001_0000, 32'hFFFE_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                16'd0, 16'd0, 16'd0, 14'd5);
    send_segment(14'd1);
    send_segment(14'd9);
    // normal along +X and -X take the fixed alternative basis
    load_circle(0, 0, 0, 31'h0002_0000, 16'sd16384, 16'd0, 16'd0, 14'd4);
    send_segment(14'd0);
    send_segment(14'd3);
    load_circle(0, 0, 0, 31'h0002_0000, 16'h8000, 16'd0, 16'd0, 14'd4);
    send_segment(14'd1);
    // extreme normal components, non-unit length
    load_circle(0, 0, 0, 31'h0001_0000, 16'h8000, 16'h7FFF, 16'h8000, 14'd6);
    send_segment(14'd2);
    send_segment(14'd5);
  endtask

  task automatic test_saturation_and_counts;
    // huge radius on an extreme centre drives coordinates into the clamp
    load_circle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                16'h7FFF, 16'h7FFF, 16'h7FFF, 14'd3);
    send_segment(14'd0);
    send_segment(14'd1);
    // count writes below three and above the maximum clamp
    drain();
    write_reg(csvg_pkg::REG_SEGMENT_COUNT, 32'hFFFF_0000);
    send_segment(14'd2);
    send_segment(14'd3);
    drain();
    write_reg(csvg_pkg::REG_SEGMENT_COUNT, 32'h0000_3FFF);
    send_segment(14'd9999);
    send_segment(14'd10000);
    send_segment(14'd0);
    // writes past the register list must leave the circle alone
    drain();
    for (int i = 0; i < 8; i++) write_reg(REG_UNUSED_BASE + 4'(i), $urandom);
    send_segment(14'd5000);
  endtask

  task automatic test_random_traffic;
    int modes[4][2] = '{'{0, 0}, '{73, 0}, '{0, 73}, '{6, 6}};
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 5; k++) begin
        load_random_circle();
        src_idle_pct   = modes[p][0];
        sink_stall_pct = modes[p][1];
        repeat (40) send_segment(pick_index());
      end
      // a stretch with no idling inside each phase
      src_idle_pct = 0;
      sink_stall_pct = 0;
      repeat (20) send_segment(pick_index());
    end
  endtask

  // Output held off for a long stretch while requests keep coming, so the
  // pipeline fills and the input stall must propagate.
  task automatic test_backpressure;
    load_random_circle();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_request = HOLD_CYCLES;
    repeat (120) send_segment(pick_index());
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall generator and result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      vtx_stall <= 1'b1;
    end else begin
      vtx_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    vertex_pair_t got, exp_v;
    if (!rst && vtx_valid && !vtx_stall) begin
      got = '{start_x, start_y, start_z, end_x, end_y, end_z, index_valid, saturated};
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected vertex pair %p", got);
      end else begin
        exp_v = expected_vertices.pop_front();
        checked++;
        if (got !== exp_v) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: vertex pair %0d\n  expected %p\n  actual   %p",
                                         checked, exp_v, got);
        end
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (seg_valid && !seg_stall) || (vtx_valid && !vtx_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (++quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    shadow_write(csvg_pkg::REG_CENTER_X, 0);
    shadow_write(csvg_pkg::REG_CENTER_Y, 0);
    shadow_write(csvg_pkg::REG_CENTER_Z, 0);
    shadow_write(csvg_pkg::REG_CIRCLE_RADIUS, 32'h0001_0000);
    shadow_write(csvg_pkg::REG_NORMAL_X, 0);
    shadow_write(csvg_pkg::REG_NORMAL_Y, 0);
    shadow_write(csvg_pkg::REG_NORMAL_Z, 32'd16384);
    shadow_write(csvg_pkg::REG_SEGMENT_COUNT, 32'd3);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_circle();
    test_basis_cases();
    test_saturation_and_counts();
    test_random_traffic();
    test_backpressure();
    drain();

    $display("tb: %0d requests, %0d vertex pairs checked, %0d register writes", sent, checked,
             cfg_writes);
    $display("tb: covered basis branches, saturation, count clamps, idle/stall mixes, full hold");
    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches, %0d pending", mismatches, expected_vertices.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
